/* hw/rtl/hrhp_pkg.sv */
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared codes, widths and character-class helpers for the HTTP request
// head parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

  // Field widths of a request and of a result
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CLASS_W   = 3;
  localparam int unsigned VER_OUT_W = 16;

  // Packed stream widths (tdata padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELD_W = STATUS_W + BYTE_W + 2 * VER_OUT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = CLASS_W + 1;

  // Commands
  localparam logic CMD_CONSUME = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_MORE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GOOD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  // Byte classes
  localparam logic [CLASS_W-1:0] CL_NONE   = 3'd0;
  localparam logic [CLASS_W-1:0] CL_METHOD = 3'd1;
  localparam logic [CLASS_W-1:0] CL_URI    = 3'd2;
  localparam logic [CLASS_W-1:0] CL_HNAME  = 3'd3;
  localparam logic [CLASS_W-1:0] CL_HVALUE = 3'd4;

  // Parse phases
  localparam int unsigned PHASE_W = 5;
  localparam logic [PHASE_W-1:0] PH_METHOD_START = 5'd0;
  localparam logic [PHASE_W-1:0] PH_METHOD       = 5'd1;
  localparam logic [PHASE_W-1:0] PH_URI          = 5'd2;
  localparam logic [PHASE_W-1:0] PH_V_H          = 5'd3;
  localparam logic [PHASE_W-1:0] PH_V_T1         = 5'd4;
  localparam logic [PHASE_W-1:0] PH_V_T2         = 5'd5;
  localparam logic [PHASE_W-1:0] PH_V_P          = 5'd6;
  localparam logic [PHASE_W-1:0] PH_V_SLASH      = 5'd7;
  localparam logic [PHASE_W-1:0] PH_MAJ_START    = 5'd8;
  localparam logic [PHASE_W-1:0] PH_MAJ          = 5'd9;
  localparam logic [PHASE_W-1:0] PH_MIN_START    = 5'd10;
  localparam logic [PHASE_W-1:0] PH_MIN          = 5'd11;
  localparam logic [PHASE_W-1:0] PH_NL1          = 5'd12;
  localparam logic [PHASE_W-1:0] PH_LINE_START   = 5'd13;
  localparam logic [PHASE_W-1:0] PH_LWS          = 5'd14;
  localparam logic [PHASE_W-1:0] PH_HNAME        = 5'd15;
  localparam logic [PHASE_W-1:0] PH_SP_VALUE     = 5'd16;
  localparam logic [PHASE_W-1:0] PH_HVALUE       = 5'd17;
  localparam logic [PHASE_W-1:0] PH_NL2          = 5'd18;
  localparam logic [PHASE_W-1:0] PH_NL3          = 5'd19;

  // Characters
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_HT    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
  localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_CTL_MAX = 8'h1F;

  // One result item before packing
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CLASS_W-1:0]  byte_class;
    logic                new_header;
  } step_res_t;

  function automatic logic is_ctl(input logic [BYTE_W-1:0] c);
    return (c <= CH_CTL_MAX) || (c == CH_DEL);
  endfunction

  function automatic logic is_num_char(input logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_special(input logic [BYTE_W-1:0] c);
    logic r;
    case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
      8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
      8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
      default:                    r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [BYTE_W-1:0] c);
    return !c[BYTE_W-1] && !is_ctl(c) && !is_special(c);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/http_request_head_parser_core.sv */
// ----------------------------------------------------------------------------
// http_request_head_parser_core
// Byte-at-a-time HTTP/1.0 request line and header checker with field
// classification and saturating version capture.
// ----------------------------------------------------------------------------
//
//  channel | ports                         | contents
//  --------+-------------------------------+-------------------------------------
//  in      | in_tvalid/in_tready/in_tdata  | one request byte, tuser = restart
//  out     | out_tvalid/out_tready/out_*   | status, echo, versions; tuser = class
//
// Each request passes an input register, then the phase logic into the result
// register; one request per cycle is sustained while out_tready stays high. The
// parse phase and version counts update as a request moves into the result
// register, so the next byte sees them in the following cycle.
// Reset (synchronous, rst_n low) returns the parser to method start with zero
// counts. A stalled result holds both stages; in_tready drops only when both
// are full and out_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_head_parser_core #(
  parameter int unsigned VERSION_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // in_tdata: [7:0] data_in
  input  wire logic [hrhp_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: [0] command
  input  wire logic                                 in_tuser,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // out_tdata: [1:0] status, [9:2] data_out, [25:10] major_version,
  //            [41:26] minor_version, [47:42] zero
  output logic [hrhp_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // out_tuser: [2:0] byte_class, [3] new_header
  output logic [hrhp_pkg::OUT_TUSER_W-1:0]          out_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready
);

  localparam int unsigned VW = VERSION_WIDTH;
  localparam int unsigned AW = VERSION_WIDTH + 4;
  localparam logic [AW-1:0] VMAX = {4'b0000, {VW{1'b1}}};

  // Input stage
  logic                          s1_valid_r;
  logic                          s1_cmd_r;
  logic [hrhp_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                          s1_adv;

  // Parser state
  logic [hrhp_pkg::PHASE_W-1:0]  phase_r,  phase_nxt;
  logic                          hdr_seen_r, hdr_seen_nxt;
  logic [VW-1:0]                 major_r,  major_nxt;
  logic [VW-1:0]                 minor_r,  minor_nxt;

  // Result stage
  logic                               out_valid_r;
  logic [hrhp_pkg::OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;
  logic [hrhp_pkg::OUT_TUSER_W-1:0]   out_user_r, out_user_nxt;

  hrhp_pkg::step_res_t           res;
  logic [hrhp_pkg::PHASE_W-1:0]  ph_try;
  logic                          hdr_try;
  logic [VW-1:0]                 maj_try, min_try;
  logic [AW-1:0]                 maj_acc, min_acc;
  logic [3:0]                    digit;
  logic [VW+15:0]                maj_ext, min_ext;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  assign digit = s1_byte_r[3:0];

  // count*10 + digit, saturating at the count width
  always_comb begin
    maj_acc = ({4'b0000, major_r} << 3) + ({4'b0000, major_r} << 1) + AW'(digit);
    min_acc = ({4'b0000, minor_r} << 3) + ({4'b0000, minor_r} << 1) + AW'(digit);
    if (maj_acc > VMAX) maj_acc = VMAX;
    if (min_acc > VMAX) min_acc = VMAX;
  end

  always_comb begin
    res.status     = hrhp_pkg::ST_MORE;
    res.byte_class = hrhp_pkg::CL_NONE;
    res.new_header = 1'b0;
    ph_try         = phase_r;
    hdr_try        = hdr_seen_r;
    maj_try        = major_r;
    min_try        = minor_r;
    unique case (phase_r)
      hrhp_pkg::PH_METHOD_START: begin
        if (hrhp_pkg::is_token(s1_byte_r)) begin
          ph_try = hrhp_pkg::PH_METHOD;
          res.byte_class = hrhp_pkg::CL_METHOD;
        end else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_METHOD: begin
        if (s1_byte_r == hrhp_pkg::CH_SP) ph_try = hrhp_pkg::PH_URI;
        else if (hrhp_pkg::is_token(s1_byte_r)) res.byte_class = hrhp_pkg::CL_METHOD;
        else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_URI: begin
        if (s1_byte_r == hrhp_pkg::CH_SP) ph_try = hrhp_pkg::PH_V_H;
        else if (hrhp_pkg::is_ctl(s1_byte_r)) res.status = hrhp_pkg::ST_BAD;
        else res.byte_class = hrhp_pkg::CL_URI;
      end
      hrhp_pkg::PH_V_H: begin
        if (s1_byte_r == hrhp_pkg::CH_H) ph_try = hrhp_pkg::PH_V_T1;
        else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_T1: begin
        if (s1_byte_r == hrhp_pkg::CH_T) ph_try = hrhp_pkg::PH_V_T2;
        else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_T2: begin
        if (s1_byte_r == hrhp_pkg::CH_T) ph_try = hrhp_pkg::PH_V_P;
        else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_P: begin
        if (s1_byte_r == hrhp_pkg::CH_P) ph_try = hrhp_pkg::PH_V_SLASH;
        else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_SLASH: begin
        if (s1_byte_r == hrhp_pkg::CH_SLASH) begin
          maj_try = '0;
          min_try = '0;
          ph_try  = hrhp_pkg::PH_MAJ_START;
        end else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MAJ_START: begin
        if (hrhp_pkg::is_num_char(s1_byte_r)) begin
          maj_try = maj_acc[VW-1:0];
          ph_try  = hrhp_pkg::PH_MAJ;
        end else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MAJ: begin
        if (s1_byte_r == hrhp_pkg::CH_DOT) ph_try = hrhp_pkg::PH_MIN_START;
        else if (hrhp_pkg::is_num_char(s1_byte_r)) maj_try = maj_acc[VW-1:0];
        else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MIN_START: begin
        if (hrhp_pkg::is_num_char(s1_byte_r)) begin
          min_try = min_acc[VW-1:0];
          ph_try  = hrhp_pkg::PH_MIN;
        end else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MIN: begin
        if (s1_byte_r == hrhp_pkg::CH_CR) ph_try = hrhp_pkg::PH_NL1;
        else if (hrhp_pkg::is_num_char(s1_byte_r)) min_try = min_acc[VW-1:0];
        else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_NL1: begin
        if (s1_byte_r == hrhp_pkg::CH_LF) ph_try = hrhp_pkg::PH_LINE_START;
        else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_LINE_START: begin
        if (s1_byte_r == hrhp_pkg::CH_CR) ph_try = hrhp_pkg::PH_NL3;
        else if (hdr_seen_r && (s1_byte_r == hrhp_pkg::CH_SP ||
                                s1_byte_r == hrhp_pkg::CH_HT)) begin
          ph_try = hrhp_pkg::PH_LWS;
        end else if (hrhp_pkg::is_token(s1_byte_r)) begin
          hdr_try        = 1'b1;
          ph_try         = hrhp_pkg::PH_HNAME;
          res.byte_class = hrhp_pkg::CL_HNAME;
          res.new_header = 1'b1;
        end else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_LWS: begin
        if (s1_byte_r == hrhp_pkg::CH_CR) ph_try = hrhp_pkg::PH_NL2;
        else if (s1_byte_r == hrhp_pkg::CH_SP || s1_byte_r == hrhp_pkg::CH_HT) begin
          ph_try = phase_r;
        end else if (hrhp_pkg::is_ctl(s1_byte_r)) res.status = hrhp_pkg::ST_BAD;
        else begin
          ph_try         = hrhp_pkg::PH_HVALUE;
          res.byte_class = hrhp_pkg::CL_HVALUE;
        end
      end
      hrhp_pkg::PH_HNAME: begin
        if (s1_byte_r == hrhp_pkg::CH_COLON) ph_try = hrhp_pkg::PH_SP_VALUE;
        else if (hrhp_pkg::is_token(s1_byte_r)) res.byte_class = hrhp_pkg::CL_HNAME;
        else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_SP_VALUE: begin
        if (s1_byte_r == hrhp_pkg::CH_SP) ph_try = hrhp_pkg::PH_HVALUE;
        else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_HVALUE: begin
        if (s1_byte_r == hrhp_pkg::CH_CR) ph_try = hrhp_pkg::PH_NL2;
        else if (hrhp_pkg::is_ctl(s1_byte_r)) res.status = hrhp_pkg::ST_BAD;
        else res.byte_class = hrhp_pkg::CL_HVALUE;
      end
      hrhp_pkg::PH_NL2: begin
        if (s1_byte_r == hrhp_pkg::CH_LF) ph_try = hrhp_pkg::PH_LINE_START;
        else res.status = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_NL3: begin
        res.status = (s1_byte_r == hrhp_pkg::CH_LF) ? hrhp_pkg::ST_GOOD
                                                    : hrhp_pkg::ST_BAD;
      end
      default: res.status = hrhp_pkg::ST_BAD;
    endcase

    // A finished or broken head keeps its phase; the fail paths never touch counts
    if (res.status != hrhp_pkg::ST_MORE) begin
      res.byte_class = hrhp_pkg::CL_NONE;
      res.new_header = 1'b0;
      ph_try         = phase_r;
    end

    if (s1_cmd_r == hrhp_pkg::CMD_RESTART) begin
      res.status     = hrhp_pkg::ST_MORE;
      res.byte_class = hrhp_pkg::CL_NONE;
      res.new_header = 1'b0;
      ph_try         = hrhp_pkg::PH_METHOD_START;
      hdr_try        = 1'b0;
      maj_try        = '0;
      min_try        = '0;
    end
  end

  // Commit state only when the request moves into the result register
  always_comb begin
    phase_nxt    = phase_r;
    hdr_seen_nxt = hdr_seen_r;
    major_nxt    = major_r;
    minor_nxt    = minor_r;
    if (s1_adv) begin
      phase_nxt    = ph_try;
      hdr_seen_nxt = hdr_try;
      major_nxt    = maj_try;
      minor_nxt    = min_try;
    end
  end

  assign maj_ext = {16'd0, maj_try};
  assign min_ext = {16'd0, min_try};

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[hrhp_pkg::OUT_FIELD_W-1:0] =
      {min_ext[15:0], maj_ext[15:0], s1_byte_r, res.status};
    out_user_nxt = {res.new_header, res.byte_class};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= hrhp_pkg::PH_METHOD_START;
      hdr_seen_r  <= 1'b0;
      major_r     <= '0;
      minor_r     <= '0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_adv) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      phase_r    <= phase_nxt;
      hdr_seen_r <= hdr_seen_nxt;
      major_r    <= major_nxt;
      minor_r    <= minor_nxt;
    end
  end

  // Payload registers: hold unless a new request lands
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_byte_r <= in_tdata[hrhp_pkg::BYTE_W-1:0];
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3))
    else $error("result status out of range");

  a_fail_no_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] != hrhp_pkg::ST_MORE) |->
      (out_tuser == '0))
    else $error("finished or malformed byte carries a class");

  a_new_hdr_name: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[hrhp_pkg::CLASS_W]) |->
      (out_tuser[hrhp_pkg::CLASS_W-1:0] == hrhp_pkg::CL_HNAME))
    else $error("new header flag outside a header name");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r == hrhp_pkg::CMD_RESTART) |=>
      (phase_r == hrhp_pkg::PH_METHOD_START && !hdr_seen_r &&
       major_r == '0 && minor_r == '0))
    else $error("restart did not clear parser state");

  a_bad_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res.status == hrhp_pkg::ST_BAD) |=> $stable(phase_r))
    else $error("malformed byte moved the parse phase");

endmodule

`default_nettype wire

/* bench/tb_http_request_head_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_http_request_head_parser_core
// Self-checking bench for the HTTP/1.0 request head parser. A byte-level
// parser model predicts status, byte class, header start, echo and version
// counts for every accepted request byte. Stimulus is mostly well-formed
// request heads with random content, plus corrupted, truncated and noisy
// sequences. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_http_request_head_parser_core;

  localparam int unsigned VER_W   = 16;
  localparam logic [31:0] VER_MAX = (32'd1 << VER_W) - 1;
  localparam int          N_RAND  = 1150;

  typedef struct {
    logic        cmd;
    logic [7:0]  data;
    bit          sync;   // wait for all results before offering this byte
  } byte_req_t;

  typedef struct packed {
    logic [hrhp_pkg::STATUS_W-1:0]  status;
    logic [hrhp_pkg::CLASS_W-1:0]   cls;
    logic                           new_hdr;
    logic [hrhp_pkg::BYTE_W-1:0]    echo;
    logic [hrhp_pkg::VER_OUT_W-1:0] major;
    logic [hrhp_pkg::VER_OUT_W-1:0] minor;
  } head_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic [hrhp_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = hrhp_pkg::CMD_CONSUME;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [hrhp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [hrhp_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;

  http_request_head_parser_core #(.VERSION_WIDTH(VER_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Parser shadow state
  logic [hrhp_pkg::PHASE_W-1:0] phase    = hrhp_pkg::PH_METHOD_START;
  logic                         hdr_seen = 1'b0;
  logic [31:0]                  maj_cnt  = '0;
  logic [31:0]                  min_cnt  = '0;

  byte_req_t    pending[$];
  head_result_t expect_q[$];
  logic [7:0]   line_buf[$];

  bit          in_taken = 1'b0;
  int          in_count = 0;
  int          results_seen = 0;
  int          errors = 0;
  int          hold_left = 0;
  int          holds = 0;
  int          heads_ok = 0;
  int          bad_seen = 0;
  int          restarts = 0;
  int          sat_seen = 0;
  int          in_stalls = 0;

  // ---------------------------------------------------------------- classes

  function automatic bit ctl_char(input logic [7:0] c);
    return (c <= hrhp_pkg::CH_CTL_MAX) || (c == hrhp_pkg::CH_DEL);
  endfunction

  function automatic bit dec_digit(input logic [7:0] c);
    return (c >= hrhp_pkg::CH_ZERO) && (c <= hrhp_pkg::CH_NINE);
  endfunction

  function automatic bit sep_char(input logic [7:0] c);
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", hrhp_pkg::CH_SP, hrhp_pkg::CH_HT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit tok_char(input logic [7:0] c);
    return !c[7] && !ctl_char(c) && !sep_char(c);
  endfunction

  function automatic logic [31:0] dec_step(input logic [31:0] v, input logic [7:0] c);
    logic [31:0] n;
    n = v * 10 + 32'(c - hrhp_pkg::CH_ZERO);
    return (n > VER_MAX) ? VER_MAX : n;
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic head_result_t parse_step(input logic cmd, input logic [7:0] c);
    head_result_t                 r;
    logic [hrhp_pkg::PHASE_W-1:0] nx;
    r.status  = hrhp_pkg::ST_MORE;
    r.cls     = hrhp_pkg::CL_NONE;
    r.new_hdr = 1'b0;
    r.echo    = c;
    nx        = phase;
    if (cmd == hrhp_pkg::CMD_RESTART) begin
      phase    = hrhp_pkg::PH_METHOD_START;
      hdr_seen = 1'b0;
      maj_cnt  = '0;
      min_cnt  = '0;
    end else begin
      case (phase)
        hrhp_pkg::PH_METHOD_START: begin
          if (tok_char(c)) begin nx = hrhp_pkg::PH_METHOD; r.cls = hrhp_pkg::CL_METHOD; end
          else r.status = hrhp_pkg::ST_BAD;
        end
        hrhp_pkg::PH_METHOD: begin
          if (c == hrhp_pkg::CH_SP) nx = hrhp_pkg::PH_URI;
          else if (tok_char(c)) r.cls = hrhp_pkg::CL_METHOD;
          else r.status = hrhp_pkg::ST_BAD;
        end
        hrhp_pkg::PH_URI: begin
          if (c == hrhp_pkg::CH_SP) nx = hrhp_pkg::PH_V_H;
          else if (ctl_char(c)) r.status = hrhp_pkg::ST_BAD;
          else r.cls = hrhp_pkg::CL_URI;
        end
        hrhp_pkg::PH_V_H:
          if (c == hrhp_pkg::CH_H) nx = hrhp_pkg::PH_V_T1; else r.status = hrhp_pkg::ST_BAD;
        hrhp_pkg::PH_V_T1:
          if (c == hrhp_pkg::CH_T) nx = hrhp_pkg::PH_V_T2; else r.status = hrhp_pkg::ST_BAD;
        hrhp_pkg::PH_V_T2:
          if (c == hrhp_pkg::CH_T) nx = hrhp_pkg::PH_V_P; else r.status = hrhp_pkg::ST_BAD;
        hrhp_pkg::PH_V_P:
          if (c == hrhp_pkg::CH_P) nx = hrhp_pkg::PH_V_SLASH;
          else r.status = hrhp_pkg::ST_BAD;
        hrhp_pkg::PH_V_SLASH: begin
          if (c == hrhp_pkg::CH_SLASH) begin
            maj_cnt = '0;
            min_cnt = '0;
            nx = hrhp_pkg::PH_MAJ_START;
          end else r.status = hrhp_pkg::ST_BAD;
        end
        hrhp_pkg::PH_MAJ_START: begin
          if (dec_digit(c)) begin maj_cnt = dec_step(maj_cnt, c); nx = hrhp_pkg::PH_MAJ; end
          else r.status = hrhp_pkg::ST_BAD;
        end
        hrhp_pkg::PH_MAJ: begin
          if (c == hrhp_pkg::CH_DOT) nx = hrhp_pkg::PH_MIN_START;
          else if (dec_digit(c)) maj_cnt = dec_step(maj_cnt, c);
          else r.status = hrhp_pkg::ST_BAD;
        end
        hrhp_pkg::PH_MIN_START: begin
          if (dec_digit(c)) begin min_cnt = dec_step(min_cnt, c); nx = hrhp_pkg::PH_MIN; end
          else r.status = hrhp_pkg::ST_BAD;
        end
        hrhp_pkg::PH_MIN: begin
          if (c == hrhp_pkg::CH_CR) nx = hrhp_pkg::PH_NL1;
          else if (dec_digit(c)) min_cnt = dec_step(min_cnt, c);
          else r.status = hrhp_pkg::ST_BAD;
        end
        hrhp_pkg::PH_NL1:
          if (c == hrhp_pkg::CH_LF) nx = hrhp_pkg::PH_LINE_START;
          else r.status = hrhp_pkg::ST_BAD;
        hrhp_pkg::PH_LINE_START: begin
          if (c == hrhp_pkg::CH_CR) nx = hrhp_pkg::PH_NL3;
          else if (hdr_seen && (c == hrhp_pkg::CH_SP || c == hrhp_pkg::CH_HT))
            nx = hrhp_pkg::PH_LWS;
          else if (tok_char(c)) begin
            hdr_seen  = 1'b1;
            nx        = hrhp_pkg::PH_HNAME;
            r.cls     = hrhp_pkg::CL_HNAME;
            r.new_hdr = 1'b1;
          end else r.status = hrhp_pkg::ST_BAD;
        end
        hrhp_pkg::PH_LWS: begin
          if (c == hrhp_pkg::CH_CR) nx = hrhp_pkg::PH_NL2;
          else if (c == hrhp_pkg::CH_SP || c == hrhp_pkg::CH_HT) nx = hrhp_pkg::PH_LWS;
          else if (ctl_char(c)) r.status = hrhp_pkg::ST_BAD;
          else begin nx = hrhp_pkg::PH_HVALUE; r.cls = hrhp_pkg::CL_HVALUE; end
        end
        hrhp_pkg::PH_HNAME: begin
          if (c == hrhp_pkg::CH_COLON) nx = hrhp_pkg::PH_SP_VALUE;
          else if (tok_char(c)) r.cls = hrhp_pkg::CL_HNAME;
          else r.status = hrhp_pkg::ST_BAD;
        end
        hrhp_pkg::PH_SP_VALUE:
          if (c == hrhp_pkg::CH_SP) nx = hrhp_pkg::PH_HVALUE;
          else r.status = hrhp_pkg::ST_BAD;
        hrhp_pkg::PH_HVALUE: begin
          if (c == hrhp_pkg::CH_CR) nx = hrhp_pkg::PH_NL2;
          else if (ctl_char(c)) r.status = hrhp_pkg::ST_BAD;
          else r.cls = hrhp_pkg::CL_HVALUE;
        end
        hrhp_pkg::PH_NL2:
          if (c == hrhp_pkg::CH_LF) nx = hrhp_pkg::PH_LINE_START;
          else r.status = hrhp_pkg::ST_BAD;
        hrhp_pkg::PH_NL3:
          r.status = (c == hrhp_pkg::CH_LF) ? hrhp_pkg::ST_GOOD : hrhp_pkg::ST_BAD;
        default: r.status = hrhp_pkg::ST_BAD;
      endcase
      // a verdict leaves the phase where it was
      if (r.status != hrhp_pkg::ST_MORE) begin
        r.cls     = hrhp_pkg::CL_NONE;
        r.new_hdr = 1'b0;
      end else begin
        phase = nx;
      end
    end
    r.major = maj_cnt[hrhp_pkg::VER_OUT_W-1:0];
    r.minor = min_cnt[hrhp_pkg::VER_OUT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic push_req(input logic cmd, input logic [7:0] b, input bit sync);
    byte_req_t r;
    r.cmd  = cmd;
    r.data = b;
    r.sync = sync;
    pending.insert(pending.size(), r);
  endtask

  task automatic line_add(input logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_add(s[i]);
  endtask

  task automatic add_crlf();
    line_add(hrhp_pkg::CH_CR);
    line_add(hrhp_pkg::CH_LF);
  endtask

  function automatic logic [7:0] rand_tok();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!tok_char(c));
    return c;
  endfunction

  // any non-control byte, high half included
  function automatic logic [7:0] rand_val(input bit no_space);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (ctl_char(c) || (no_space && c == hrhp_pkg::CH_SP));
    return c;
  endfunction

  task automatic add_digits();
    int n;
    // long runs push the count into saturation
    n = ($urandom_range(99) < 15) ? $urandom_range(5, 7) : $urandom_range(1, 2);
    repeat (n) line_add(8'(hrhp_pkg::CH_ZERO + $urandom_range(9)));
  endtask

  task automatic build_head();
    int n;
    int k;
    line_buf.delete();
    n = $urandom_range(1, 6);
    repeat (n) line_add(rand_tok());
    line_add(hrhp_pkg::CH_SP);
    n = $urandom_range(1, 10);
    repeat (n) line_add(rand_val(1'b1));
    add_text(" HTTP/");
    add_digits();
    line_add(hrhp_pkg::CH_DOT);
    add_digits();
    add_crlf();
    // continuation with no header yet is malformed
    if ($urandom_range(99) < 5) begin
      line_add(hrhp_pkg::CH_HT);
      add_text("x");
      add_crlf();
    end
    n = $urandom_range(0, 3);
    repeat (n) begin
      k = $urandom_range(1, 6);
      repeat (k) line_add(rand_tok());
      line_add(hrhp_pkg::CH_COLON);
      line_add(hrhp_pkg::CH_SP);
      k = $urandom_range(0, 8);
      repeat (k) line_add(rand_val(1'b0));
      add_crlf();
      if ($urandom_range(99) < 30) begin
        k = $urandom_range(1, 2);
        repeat (k) line_add($urandom_range(1) ? hrhp_pkg::CH_SP : hrhp_pkg::CH_HT);
        k = $urandom_range(0, 5);
        repeat (k) line_add(rand_val(1'b0));
        add_crlf();
      end
    end
    add_crlf();
    k = $urandom_range(99);
    if (k < 20) line_add(hrhp_pkg::CH_LF);
    else if (k < 28) line_add(8'($urandom));
  endtask

  task automatic send_head(input bit sync);
    int cut;
    build_head();
    if (sync || $urandom_range(99) < 95)
      push_req(hrhp_pkg::CMD_RESTART, 8'($urandom), sync);
    if ($urandom_range(99) < 15)
      line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom);
    cut = line_buf.size();
    if ($urandom_range(99) < 10) cut = $urandom_range(1, line_buf.size());
    for (int i = 0; i < cut; i++) push_req(hrhp_pkg::CMD_CONSUME, line_buf[i], 1'b0);
  endtask

  function automatic bit quiet_window();
    return in_count >= 400 && in_count < 600;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 40)
      $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    head_result_t got;
    head_result_t want;
    head_result_t pred;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && !in_tready) in_stalls++;
      if (out_tvalid && out_tready) begin
        got.status  = out_tdata[1:0];
        got.echo    = out_tdata[9:2];
        got.major   = out_tdata[25:10];
        got.minor   = out_tdata[41:26];
        got.cls     = out_tuser[2:0];
        got.new_hdr = out_tuser[3];
        if (expect_q.size() == 0) begin
          report_mismatch("with nothing pending, status", 32'(got.status), '0);
        end else begin
          want = expect_q.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.cls !== want.cls)
            report_mismatch("byte_class", 32'(got.cls), 32'(want.cls));
          if (got.new_hdr !== want.new_hdr)
            report_mismatch("new_header", 32'(got.new_hdr), 32'(want.new_hdr));
          if (got.echo !== want.echo)
            report_mismatch("data_out", 32'(got.echo), 32'(want.echo));
          if (got.major !== want.major)
            report_mismatch("major_version", 32'(got.major), 32'(want.major));
          if (got.minor !== want.minor)
            report_mismatch("minor_version", 32'(got.minor), 32'(want.minor));
          if (want.status == hrhp_pkg::ST_GOOD) heads_ok++;
          if (want.status == hrhp_pkg::ST_BAD) bad_seen++;
          if (want.major == VER_MAX[hrhp_pkg::VER_OUT_W-1:0] ||
              want.minor == VER_MAX[hrhp_pkg::VER_OUT_W-1:0])
            sat_seen++;
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == hrhp_pkg::CMD_RESTART) restarts++;
        pred = parse_step(in_tuser, in_tdata);
        expect_q.insert(expect_q.size(), pred);
        in_count++;
      end
    end else begin
      in_taken <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin : driver
    bit        idle;
    byte_req_t req;
    if (rst_n && (in_taken || !in_tvalid)) begin
      // keep offering while the receiver holds off, so the pipe fills up
      idle = !quiet_window() && hold_left == 0 && ($urandom_range(99) < 38);
      if (pending.size() == 0 || idle || (pending[0].sync && expect_q.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        req = pending.pop_front();
        in_tdata  <= req.data;
        in_tuser  <= req.cmd;
        in_tvalid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (rst_n) begin
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if ((holds == 0 && results_seen >= 250) ||
                   (holds == 1 && results_seen >= 900)) begin
        out_tready <= 1'b0;
        hold_left  <= 60;
        holds      <= holds + 1;
      end else begin
        out_tready <= quiet_window() || ($urandom_range(99) >= 38);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : main
    int heads;
    int base;
    // extremes of the byte and both commands
    push_req(hrhp_pkg::CMD_RESTART, 8'hFF, 1'b0);
    push_req(hrhp_pkg::CMD_CONSUME, 8'h00, 1'b0);
    push_req(hrhp_pkg::CMD_CONSUME, 8'hFF, 1'b0);
    push_req(hrhp_pkg::CMD_RESTART, 8'h00, 1'b0);
    // shortest complete head, then a LF and a high byte after completion
    line_buf.delete();
    add_text("G / HTTP/1.0");
    add_crlf();
    add_crlf();
    line_add(hrhp_pkg::CH_LF);
    line_add(8'h80);
    foreach (line_buf[i]) push_req(hrhp_pkg::CMD_CONSUME, line_buf[i], 1'b0);

    base  = pending.size();
    heads = 0;
    while (pending.size() - base < N_RAND) begin
      if ($urandom_range(99) < 5) begin
        repeat ($urandom_range(1, 4))
          push_req(($urandom_range(99) < 20) ? hrhp_pkg::CMD_RESTART
                                              : hrhp_pkg::CMD_CONSUME,
                   8'($urandom), 1'b0);
      end else begin
        send_head(heads % 30 == 29);
        heads++;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_tvalid) @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d results from %0d requests (%0d restarts, %0d input stalls)",
             results_seen, in_count, restarts, in_stalls);
    $display("Heads completed %0d, malformed verdicts %0d, saturated versions %0d",
             heads_ok, bad_seen, sat_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #200000;
    $display("Timeout with %0d results outstanding", expect_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/hrhp_pkg.sv
hw/rtl/http_request_head_parser_core.sv
bench/tb_http_request_head_parser_core.sv
